/* hdl/olid_pkg.sv */
// Package for the ordered list unit: field widths, operation and status codes,
// and the control bundle that drives the chain of storage cells.
// No dependencies.
package olid_pkg;

    localparam int unsigned DEPTH_DEF = 32;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CNT_W     = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_FORWARD = 2'd2,
        OP_REVERSE = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    // Per-cycle command shared by every cell of the chain.
    typedef struct packed {
        logic wr_new;   // load the appended value into the cell at the write index
        logic shift_l;  // rotate toward the head, the head value re-enters at the tail
        logic shift_r;  // rotate toward the tail, the tail value re-enters at the head
        logic drop;     // during a left shift, the head value does not re-enter
    } t_cell_ctrl;

endpackage

/* hdl/olid_in_if.sv */
// Input channel of the ordered list unit: valid/ready handshake plus the operation fields.
// Depends on olid_pkg.
interface olid_in_if;
    logic                              valid;
    logic                              ready;
    logic [olid_pkg::OP_W-1:0]         operation;
    logic signed [olid_pkg::VAL_W-1:0] new_value;
    logic [olid_pkg::POS_W-1:0]        position;

    modport source (output valid, output operation, output new_value, output position,
                    input ready);
    modport sink (input valid, input operation, input new_value, input position,
                  output ready);
endinterface

/* hdl/olid_out_if.sv */
// Output channel of the ordered list unit: valid/ready handshake plus the result fields.
// Depends on olid_pkg.
interface olid_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [olid_pkg::VAL_W-1:0]  item_value;
    logic [olid_pkg::STAT_W-1:0]        status;
    logic                               last_of_run;
    logic [olid_pkg::CNT_W-1:0]         list_count;
    logic signed [olid_pkg::VAL_W-1:0]  list_max;

    modport source (output valid, output item_value, output status, output last_of_run,
                    output list_count, output list_max, input ready);
    modport sink (input valid, input item_value, input status, input last_of_run,
                  input list_count, input list_max, output ready);
endinterface

/* hdl/ordered_list_indexed_delete_unit.sv */
// Ordered list unit with indexed delete. It keeps up to DEPTH signed 32-bit values in
// insertion order in a chain of storage cells, one element per cell, and serves four
// operations: append at the tail, delete at an index, list front to back and list back
// to front. Items are handled one at a time; the input is ready only while the unit is
// idle. Every pass over the list rotates the chain by one element per cycle, so timing
// follows the element count; the listing pass holds still while the output register
// waits for the sink. A listing (or an append, which lists the new list) takes one pass
// to find the maximum and a second pass that hands one result transaction per cycle to
// the output as the sink allows. A delete, a delete with an index out of range and an
// append to a full list take one pass and then give one result. Listings and deletes on
// an empty list give their single result without a pass. The output stage is a
// register, so a result may wait for the sink while the chain holds still. Every result
// carries the element count and the largest element after the operation (zero if empty).
// Depends on olid_pkg, olid_in_if, olid_out_if and olid_cell.
module ordered_list_indexed_delete_unit #(
    parameter int unsigned DEPTH = olid_pkg::DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    olid_in_if.sink    i_in,
    olid_out_if.source o_out
);

    localparam int unsigned IW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W;
    localparam int unsigned VW    = olid_pkg::VAL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_RESULT
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_len;
    logic [CW-1:0]                r_step;
    logic [olid_pkg::POS_W-1:0]   r_pos;
    logic                         r_drop_en;
    logic                         r_emit;
    logic                         r_rev;
    logic signed [VW-1:0]         r_max;
    logic                         r_max_any;
    logic signed [VW-1:0]         r_res_val;
    olid_pkg::t_status            r_status;

    logic                         r_o_valid;
    logic signed [VW-1:0]         r_o_value;
    olid_pkg::t_status            r_o_status;
    logic                         r_o_last;
    logic [olid_pkg::CNT_W-1:0]   r_o_count;
    logic signed [VW-1:0]         r_o_max;

    logic signed [VW-1:0]         w_cell [DEPTH];
    logic signed [VW-1:0]         w_head;
    logic signed [VW-1:0]         w_tail_val;
    logic [IW-1:0]                w_tail_idx;
    logic [IW-1:0]                w_wr_idx;
    olid_pkg::t_cell_ctrl         w_ctrl;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_o_load;
    logic                         w_full;
    logic                         w_drop;
    logic                         w_pos_bad;
    logic                         w_emit_last;
    logic signed [VW-1:0]         w_max_out;
    olid_pkg::t_op                w_op;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_o_valid || o_out.ready;
    // The output register takes a new result in this cycle.
    assign w_o_load    = w_out_free && ((r_state == ST_EMIT) || (r_state == ST_RESULT));
    assign w_op        = olid_pkg::t_op'(i_in.operation);
    assign w_full      = (r_cnt >= CW'(DEPTH));
    assign w_pos_bad   = (CMP_W'(i_in.position) >= CMP_W'(r_cnt));
    assign w_drop      = r_drop_en && (CMP_W'(r_step) == CMP_W'(r_pos));
    assign w_emit_last = (r_step == (r_cnt - CW'(1)));
    assign w_max_out   = r_max_any ? r_max : '0;

    // The tail index is only used while the list holds at least one element.
    assign w_tail_idx  = IW'(r_cnt - CW'(1));
    assign w_wr_idx    = IW'(r_cnt);
    assign w_head      = w_cell[0];
    assign w_tail_val  = w_cell[w_tail_idx];

    always_comb begin
        w_ctrl = '0;
        w_ctrl.wr_new = w_accept && (w_op == olid_pkg::OP_APPEND) && !w_full;
        case (r_state)
            ST_SCAN: begin
                w_ctrl.shift_l = 1'b1;
                w_ctrl.drop    = w_drop;
            end
            ST_EMIT: begin
                w_ctrl.shift_l = w_out_free && !r_rev;
                w_ctrl.shift_r = w_out_free && r_rev;
            end
            default: begin
            end
        endcase
    end

    // Chain of cells; the ends wrap through the head and tail inputs.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VW-1:0] w_left;
        logic signed [VW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_tail_val;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_head;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        olid_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_tail_idx (w_tail_idx),
            .i_wr_idx   (w_wr_idx),
            .i_new      (i_in.new_value),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_head     (w_head),
            .i_tail     (w_tail_val),
            .o_value    (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready && !w_o_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_step    <= '0;
                        r_max_any <= 1'b0;
                        r_pos     <= i_in.position;
                        case (w_op)
                            olid_pkg::OP_APPEND: begin
                                r_drop_en <= 1'b0;
                                r_rev     <= 1'b0;
                                if (w_full) begin
                                    r_status  <= olid_pkg::STAT_FULL;
                                    r_res_val <= '0;
                                    r_len     <= r_cnt;
                                    r_emit    <= 1'b0;
                                end else begin
                                    // The new value is written now; both passes see it.
                                    r_cnt  <= r_cnt + CW'(1);
                                    r_len  <= r_cnt + CW'(1);
                                    r_emit <= 1'b1;
                                end
                                r_state <= ST_SCAN;
                            end
                            olid_pkg::OP_DELETE: begin
                                r_res_val <= '1;
                                r_len     <= r_cnt;
                                r_emit    <= 1'b0;
                                r_rev     <= 1'b0;
                                if (r_cnt == '0) begin
                                    r_status  <= olid_pkg::STAT_EMPTY;
                                    r_drop_en <= 1'b0;
                                    r_state   <= ST_RESULT;
                                end else if (w_pos_bad) begin
                                    r_status  <= olid_pkg::STAT_RANGE;
                                    r_drop_en <= 1'b0;
                                    r_state   <= ST_SCAN;
                                end else begin
                                    r_status  <= olid_pkg::STAT_OK;
                                    r_drop_en <= 1'b1;
                                    r_state   <= ST_SCAN;
                                end
                            end
                            default: begin
                                r_res_val <= '0;
                                r_len     <= r_cnt;
                                r_drop_en <= 1'b0;
                                r_rev     <= (w_op == olid_pkg::OP_REVERSE);
                                if (r_cnt == '0) begin
                                    r_status <= olid_pkg::STAT_EMPTY;
                                    r_emit   <= 1'b0;
                                    r_state  <= ST_RESULT;
                                end else begin
                                    r_emit  <= 1'b1;
                                    r_state <= ST_SCAN;
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // One element passes the head per cycle; the dropped one is kept aside
                    // and left out of the maximum.
                    if (w_drop) begin
                        r_res_val <= w_head;
                        r_cnt     <= r_cnt - CW'(1);
                    end else if (!r_max_any || (w_head > r_max)) begin
                        r_max     <= w_head;
                        r_max_any <= 1'b1;
                    end
                    if (r_step == (r_len - CW'(1))) begin
                        r_step  <= '0;
                        r_state <= r_emit ? ST_EMIT : ST_RESULT;
                    end else begin
                        r_step <= r_step + CW'(1);
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_value  <= r_rev ? w_tail_val : w_head;
                        r_o_status <= olid_pkg::STAT_OK;
                        r_o_last   <= w_emit_last;
                        r_o_count  <= olid_pkg::CNT_W'(r_cnt);
                        r_o_max    <= w_max_out;
                        if (w_emit_last) begin
                            r_step  <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_step <= r_step + CW'(1);
                        end
                    end
                end
                ST_RESULT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_value  <= r_res_val;
                        r_o_status <= r_status;
                        r_o_last   <= 1'b1;
                        r_o_count  <= olid_pkg::CNT_W'(r_cnt);
                        r_o_max    <= w_max_out;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.item_value  = r_o_value;
    assign o_out.status      = r_o_status;
    assign o_out.last_of_run = r_o_last;
    assign o_out.list_count  = r_o_count;
    assign o_out.list_max    = r_o_max;

    // The element count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("element count above capacity");

    // A pass never runs beyond the length it started with.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_step < r_len))
        else $error("scan step beyond pass length");

    // An accepted append into a list with room grows the count by one.
    a_append_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == olid_pkg::OP_APPEND) && !w_full)
            |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("append did not grow the list");

    // Back in idle, a pending result must be the closing one of its transaction run.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && r_o_valid) |-> r_o_last)
        else $error("idle with an unfinished result run");

endmodule

/* hdl/olid_cell.sv */
// One storage cell of the list chain. It holds a single element and takes its
// next value from a neighbor, the head, the tail or the appended value.
// Depends on olid_pkg.
module olid_cell #(
    parameter int unsigned DEPTH = olid_pkg::DEPTH_DEF,
    parameter int unsigned IDX   = 0
) (
    input  logic                              i_clk,
    input  olid_pkg::t_cell_ctrl              i_ctrl,
    input  logic [$clog2(DEPTH)-1:0]          i_tail_idx,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_idx,
    input  logic signed [olid_pkg::VAL_W-1:0] i_new,
    input  logic signed [olid_pkg::VAL_W-1:0] i_left,
    input  logic signed [olid_pkg::VAL_W-1:0] i_right,
    input  logic signed [olid_pkg::VAL_W-1:0] i_head,
    input  logic signed [olid_pkg::VAL_W-1:0] i_tail,
    output logic signed [olid_pkg::VAL_W-1:0] o_value
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [olid_pkg::VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_new && (i_wr_idx == MY_IDX)) begin
            r_value <= i_new;
        end else if (i_ctrl.shift_l) begin
            // The tail cell takes the old head so that a full pass restores the order.
            if (!i_ctrl.drop && (i_tail_idx == MY_IDX)) begin
                r_value <= i_head;
            end else begin
                r_value <= i_right;
            end
        end else if (i_ctrl.shift_r) begin
            if (IDX == 0) begin
                r_value <= i_tail;
            end else begin
                r_value <= i_left;
            end
        end
    end

    assign o_value = r_value;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list unit: a scoreboard class mirrors the list
// and predicts every result; tasks drive the input channel, a loop drives output ready.
// Depends on olid_pkg, olid_in_if, olid_out_if and ordered_list_indexed_delete_unit.

typedef struct packed {
    logic signed [olid_pkg::VAL_W-1:0] item_value;
    olid_pkg::t_status                 status;
    logic                              last_of_run;
    logic [olid_pkg::CNT_W-1:0]        list_count;
    logic signed [olid_pkg::VAL_W-1:0] list_max;
} t_result;

// Mirrors the stored list and queues the results that each accepted operation must give.
class list_scoreboard;
    localparam logic signed [olid_pkg::VAL_W-1:0] FAILED_DELETE_VALUE = -1;

    logic signed [olid_pkg::VAL_W-1:0] stored_values[$];
    t_result                           expected_results[$];
    int unsigned                       mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int unsigned count();
        return stored_values.size();
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    // Largest stored element by signed order, zero for an empty list.
    function logic signed [olid_pkg::VAL_W-1:0] largest();
        logic signed [olid_pkg::VAL_W-1:0] m;
        m = '0;
        foreach (stored_values[i])
            if (i == 0 || stored_values[i] > m) m = stored_values[i];
        return m;
    endfunction

    // Count and maximum always describe the list after the operation.
    function void push_result(logic signed [olid_pkg::VAL_W-1:0] value,
                              olid_pkg::t_status status, logic last);
        t_result r;
        r.item_value  = value;
        r.status      = status;
        r.last_of_run = last;
        r.list_count  = olid_pkg::CNT_W'(stored_values.size());
        r.list_max    = largest();
        expected_results.push_back(r);
    endfunction

    function void push_listing(bit reverse);
        int n;
        n = stored_values.size();
        if (n == 0) begin
            push_result('0, olid_pkg::STAT_EMPTY, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
            push_result(stored_values[reverse ? n - 1 - i : i], olid_pkg::STAT_OK, i == n - 1);
    endfunction

    function void note_operation(olid_pkg::t_op op, logic signed [olid_pkg::VAL_W-1:0] value,
                                 logic [olid_pkg::POS_W-1:0] pos);
        logic signed [olid_pkg::VAL_W-1:0] removed;
        case (op)
            olid_pkg::OP_APPEND: begin
                if (stored_values.size() >= olid_pkg::DEPTH_DEF) begin
                    push_result('0, olid_pkg::STAT_FULL, 1'b1);
                end else begin
                    stored_values.push_back(value);
                    push_listing(1'b0);
                end
            end
            olid_pkg::OP_DELETE: begin
                if (stored_values.size() == 0) begin
                    push_result(FAILED_DELETE_VALUE, olid_pkg::STAT_EMPTY, 1'b1);
                end else if (int'(pos) >= stored_values.size()) begin
                    push_result(FAILED_DELETE_VALUE, olid_pkg::STAT_RANGE, 1'b1);
                end else begin
                    removed = stored_values[pos];
                    stored_values.delete(pos);
                    push_result(removed, olid_pkg::STAT_OK, 1'b1);
                end
            end
            olid_pkg::OP_FORWARD: push_listing(1'b0);
            default:              push_listing(1'b1);
        endcase
    endfunction

    function void flag(string what, logic [olid_pkg::VAL_W-1:0] want,
                       logic [olid_pkg::VAL_W-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want, got);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            flag("unexpected result, item_value", 'x, got.item_value);
            return;
        end
        want = expected_results.pop_front();
        if (got.item_value !== want.item_value)
            flag("item_value", want.item_value, got.item_value);
        if (got.status !== want.status)
            flag("status", olid_pkg::VAL_W'(want.status), olid_pkg::VAL_W'(got.status));
        if (got.last_of_run !== want.last_of_run)
            flag("last_of_run", olid_pkg::VAL_W'(want.last_of_run),
                 olid_pkg::VAL_W'(got.last_of_run));
        if (got.list_count !== want.list_count)
            flag("list_count", olid_pkg::VAL_W'(want.list_count),
                 olid_pkg::VAL_W'(got.list_count));
        if (got.list_max !== want.list_max)
            flag("list_max", want.list_max, got.list_max);
    endfunction
endclass

module testbench;
    localparam int unsigned RANDOM_ITEMS = 400;
    // The tail wait grows with the list depth, to catch stray results after the drain.
    localparam int unsigned TAIL_CYCLES  = 2 * olid_pkg::DEPTH_DEF + 16;
    localparam int unsigned DRAIN_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;

    olid_in_if  in_ch();
    olid_out_if out_ch();

    ordered_list_indexed_delete_unit #(
        .DEPTH(olid_pkg::DEPTH_DEF)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    list_scoreboard sb;
    t_result        observed;
    int unsigned    burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop, several times the slowest legal run: every transaction a full listing
    // with each result held back by the longest sink stall.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Sink side. The ready pattern switches among four modes at random intervals:
    // always ready, coin flip, a fixed 2-of-5 stall rhythm, and long stall stretches.
    // Since a single result can wait on ready, stalls land on every phase of a listing.
    initial begin
        int unsigned sink_mode;
        int unsigned mode_left;
        int unsigned hold;
        int unsigned rhythm;
        bit          stalled;
        sink_mode = 0;
        mode_left = 0;
        hold      = 0;
        rhythm    = 0;
        stalled   = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                sink_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (sink_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: begin
                    rhythm++;
                    out_ch.ready <= (rhythm % 5) >= 2;
                end
                default: begin
                    if (hold == 0) begin
                        stalled = !stalled;
                        hold    = stalled ? $urandom_range(1, 12) : $urandom_range(1, 8);
                    end
                    hold--;
                    out_ch.ready <= !stalled;
                end
            endcase
        end
    end

    // Every result transaction is checked against the oldest prediction. Values are
    // taken at the edge, before the unit's own updates for that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            observed.item_value  = out_ch.item_value;
            observed.status      = olid_pkg::t_status'(out_ch.status);
            observed.last_of_run = out_ch.last_of_run;
            observed.list_count  = out_ch.list_count;
            observed.list_max    = out_ch.list_max;
            sb.check_result(observed);
        end
    end

    // Presents one operation and holds it until the unit takes it. The sender works in
    // bursts: valid stays high across a burst and may drop for a random gap between bursts;
    // valid is held low through a whole gap, so it is never lowered and raised in one step.
    task automatic send_item(input olid_pkg::t_op op,
                             input logic signed [olid_pkg::VAL_W-1:0] value,
                             input logic [olid_pkg::POS_W-1:0] pos);
        int unsigned gap;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.new_value <= value;
        in_ch.position  <= pos;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        sb.note_operation(op, value, pos);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Mostly random words, with a share of extremes and small values so that ties
    // and sign boundaries show up in the maximum.
    function automatic logic signed [olid_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return {1'b1, {(olid_pkg::VAL_W-1){1'b0}}};
            1:       return {1'b0, {(olid_pkg::VAL_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return olid_pkg::VAL_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Walks the special cases by hand: every operation on an empty list, the value
    // extremes, deletes at the head, the tail and the middle, and out-of-range indexes.
    task automatic run_directed();
        send_item(olid_pkg::OP_FORWARD, $urandom, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_REVERSE, $urandom, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_DELETE,  $urandom, '0);
        send_item(olid_pkg::OP_DELETE,  $urandom, '1);
        send_item(olid_pkg::OP_APPEND,  {1'b1, {(olid_pkg::VAL_W-1){1'b0}}},
                  olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  {1'b0, {(olid_pkg::VAL_W-1){1'b1}}},
                  olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  '0, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  '1, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  32'sd5, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_FORWARD, $urandom, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_REVERSE, $urandom, olid_pkg::POS_W'($urandom));
        // Index equal to the count, then the largest index the field can carry.
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(5));
        send_item(olid_pkg::OP_DELETE,  $urandom, '1);
        // Head, tail and middle deletes.
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(0));
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(3));
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(1));
        send_item(olid_pkg::OP_FORWARD, $urandom, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(0));
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(0));
        send_item(olid_pkg::OP_REVERSE, $urandom, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  32'sh5555_5555, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_APPEND,  32'shAAAA_AAAA, olid_pkg::POS_W'($urandom));
        send_item(olid_pkg::OP_DELETE,  $urandom, olid_pkg::POS_W'(42));
    endtask

    // Random operations in phases of fifty: a fill phase that pushes the list toward full,
    // a drain phase that pushes it toward empty, and a mixed phase.
    // Most deletes hit a stored index; the rest use any index the field allows.
    task automatic run_random(input int unsigned n);
        int unsigned                roll;
        int unsigned                append_pct;
        int unsigned                delete_pct;
        int unsigned                cnt;
        olid_pkg::t_op              op;
        logic [olid_pkg::POS_W-1:0] pos;
        for (int unsigned k = 0; k < n; k++) begin
            case ((k / 50) % 3)
                0: begin
                    append_pct = 70;
                    delete_pct = 15;
                end
                1: begin
                    append_pct = 20;
                    delete_pct = 65;
                end
                default: begin
                    append_pct = 40;
                    delete_pct = 35;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < append_pct)
                op = olid_pkg::OP_APPEND;
            else if (roll < append_pct + delete_pct)
                op = olid_pkg::OP_DELETE;
            else
                op = ($urandom_range(0, 1) == 0) ? olid_pkg::OP_FORWARD : olid_pkg::OP_REVERSE;
            cnt = sb.count();
            if (cnt > 0 && $urandom_range(0, 9) < 8)
                pos = olid_pkg::POS_W'($urandom_range(0, cnt - 1));
            else
                pos = olid_pkg::POS_W'($urandom_range(0, (1 << olid_pkg::POS_W) - 1));
            send_item(op, pick_value(), pos);
        end
    endtask

    initial begin
        int unsigned drain_cycles;
        sb         = new();
        burst_left = 0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= olid_pkg::OP_APPEND;
        in_ch.new_value <= '0;
        in_ch.position  <= '0;
        i_rst_n         <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_ITEMS);
        in_ch.valid <= 1'b0;

        // Let the outstanding results arrive, then watch a while longer for strays.
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.mismatches += sb.pending();
        end
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
